// ----- rtl/qtt_pkg.sv -----
// Shared types, codes and constants of the quorum transaction tracker.
`default_nettype none
package qtt_pkg;

  localparam int TRANS_SLOTS_DEF = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_QUORUM_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WAIT_TIME    = 2'd1;

  localparam logic [2:0]  QUORUM_COUNT_RST = 3'd2;
  localparam logic [15:0] WAIT_TIME_RST    = 16'd20;

  localparam logic [1:0] KIND_READ = 2'd1;

  localparam logic [1:0] OUTCOME_QUORUM  = 2'd0;
  localparam logic [1:0] OUTCOME_TIMEOUT = 2'd1;
  localparam logic [1:0] OUTCOME_FULL    = 2'd2;

  typedef enum logic [1:0] {
    ACT_OPEN        = 2'd0,
    ACT_WRITE_REPLY = 2'd1,
    ACT_READ_REPLY  = 2'd2,
    ACT_TICK        = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_UPDATE,
    ST_SCAN,
    ST_FLUSH
  } back_state_t;

  typedef struct packed {
    action_t     action;
    logic [15:0] trans_id;
    logic [1:0]  kind;
    logic        ok;
    logic        found;
    logic [15:0] reply_stamp;
    logic [31:0] reply_value;
    logic [15:0] now_time;
  } item_t;

  typedef struct packed {
    action_t     action;
    logic [15:0] id;
    logic [1:0]  kind;
    logic [15:0] stamp;
    logic [31:0] value;
    logic [15:0] now;
  } cmd_t;

  typedef struct packed {
    logic [15:0] id;
    logic [1:0]  kind;
    logic [2:0]  left;
    logic [15:0] start;
    logic [15:0] best_stamp;
    logic [31:0] best_value;
  } entry_t;

  typedef struct packed {
    logic [15:0] id;
    logic [1:0]  kind;
    logic [1:0]  outcome;
    logic [31:0] value;
    logic        last;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/qtt_front.sv -----
// Front stage: accept a transaction, drop failed or empty replies, feed the queue.
`default_nettype none
module qtt_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire qtt_pkg::item_t item,
  output logic               push_valid,
  input  wire logic          push_ready,
  output qtt_pkg::cmd_t      push_cmd
);

  logic          hold_valid;
  qtt_pkg::cmd_t hold_cmd;
  logic          accept;
  logic          keep;
  qtt_pkg::cmd_t cmd;

  always_comb begin
    unique case (item.action)
      qtt_pkg::ACT_WRITE_REPLY: keep = item.ok;
      qtt_pkg::ACT_READ_REPLY:  keep = item.found;
      default:                  keep = 1'b1;
    endcase
    cmd.action = item.action;
    cmd.id     = item.trans_id;
    cmd.kind   = item.kind;
    cmd.stamp  = item.reply_stamp;
    cmd.value  = item.reply_value;
    cmd.now    = item.now_time;
  end

  assign busy       = hold_valid & ~push_ready;
  assign accept     = start & ~busy;
  assign push_valid = hold_valid;
  assign push_cmd   = hold_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= keep;
    end else if (push_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_cmd <= cmd;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/qtt_queue.sv -----
// Short command queue between the front stage and the table engine.
`default_nettype none
module qtt_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire qtt_pkg::cmd_t in_cmd,
  output logic               out_valid,
  input  wire logic          out_pop,
  output qtt_pkg::cmd_t      out_cmd
);

  localparam int PTR_W = $clog2(qtt_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(qtt_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(qtt_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(qtt_pkg::QUEUE_DEPTH);

  qtt_pkg::cmd_t    entries [qtt_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign in_ready  = (count != CNT_FULL);
  assign out_valid = (count != '0);
  assign out_cmd   = entries[rd_ptr];
  assign do_push   = in_valid & in_ready;
  assign do_pop    = out_pop & out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= in_cmd;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/qtt_back.sv -----
// Table engine: slot table, id lookup, reply count-down and timeout scan.
`default_nettype none
module qtt_back #(
  parameter int TRANS_SLOTS = qtt_pkg::TRANS_SLOTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire qtt_pkg::cmd_t q_cmd,
  output logic               q_pop,
  input  wire logic [2:0]    quorum_count,
  input  wire logic [15:0]   wait_time,
  output logic               res_valid,
  output qtt_pkg::result_t   res
);

  localparam int IDX_W = $clog2(TRANS_SLOTS);
  localparam int CNT_W = $clog2(qtt_pkg::MAX_RESULTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TRANS_SLOTS - 1);
  localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(qtt_pkg::MAX_RESULTS - 1);

  qtt_pkg::back_state_t state;
  qtt_pkg::back_state_t state_next;

  logic [TRANS_SLOTS-1:0] slot_valid;
  logic [15:0]            slot_id [TRANS_SLOTS];
  qtt_pkg::entry_t        table_mem [TRANS_SLOTS];
  qtt_pkg::entry_t        rd_data;

  qtt_pkg::cmd_t    cur;
  logic [IDX_W-1:0] cur_idx;

  logic [IDX_W-1:0] scan_idx;
  logic             scan_issue;
  logic             chk_vld;
  logic [IDX_W-1:0] chk_idx;
  logic             chk_end;
  logic             pend_vld;
  logic [15:0]      pend_id;
  logic [1:0]       pend_kind;
  logic [CNT_W-1:0] tcount;

  logic             free_hit;
  logic [IDX_W-1:0] free_idx;
  logic             match_hit;
  logic [IDX_W-1:0] match_idx;

  logic             keep_new;
  logic             reach;
  qtt_pkg::entry_t  upd;
  logic [15:0]      elapsed;
  logic             expire;
  logic             cap;
  logic             scan_finish;

  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  qtt_pkg::entry_t  mem_wd;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             set_valid;
  logic             clr_valid;
  logic [IDX_W-1:0] clr_idx;
  logic             emit;
  qtt_pkg::result_t emit_res;

  // Lowest free slot and lowest live slot with a matching id.
  always_comb begin
    free_hit  = 1'b0;
    free_idx  = '0;
    match_hit = 1'b0;
    match_idx = '0;
    for (int i = TRANS_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_hit = 1'b1;
        free_idx = IDX_W'(i);
      end
      if (slot_valid[i] && (slot_id[i] == cur.id)) begin
        match_hit = 1'b1;
        match_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    keep_new = (cur.action == qtt_pkg::ACT_READ_REPLY) && (cur.stamp >= rd_data.best_stamp);
    reach    = (rd_data.left <= 3'd1);
    upd      = rd_data;
    if (keep_new) begin
      upd.best_stamp = cur.stamp;
      upd.best_value = cur.value;
    end
    upd.left    = reach ? 3'd0 : rd_data.left - 3'd1;
    elapsed     = cur.now - rd_data.start;
    expire      = chk_vld && (elapsed > wait_time);
    cap         = expire && (tcount == CAP_CNT);
    scan_finish = chk_end && !expire && !pend_vld;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      qtt_pkg::ST_IDLE: begin
        if (q_valid) state_next = qtt_pkg::ST_EXEC;
      end
      qtt_pkg::ST_EXEC: begin
        unique case (cur.action)
          qtt_pkg::ACT_WRITE_REPLY, qtt_pkg::ACT_READ_REPLY: begin
            if (match_hit) state_next = qtt_pkg::ST_UPDATE;
            else state_next = q_valid ? qtt_pkg::ST_EXEC : qtt_pkg::ST_IDLE;
          end
          qtt_pkg::ACT_TICK: state_next = qtt_pkg::ST_SCAN;
          default: state_next = q_valid ? qtt_pkg::ST_EXEC : qtt_pkg::ST_IDLE;
        endcase
      end
      qtt_pkg::ST_UPDATE: begin
        state_next = q_valid ? qtt_pkg::ST_EXEC : qtt_pkg::ST_IDLE;
      end
      qtt_pkg::ST_SCAN: begin
        if (cap) begin
          state_next = qtt_pkg::ST_FLUSH;
        end else if (chk_end) begin
          if (pend_vld || expire) state_next = qtt_pkg::ST_FLUSH;
          else state_next = q_valid ? qtt_pkg::ST_EXEC : qtt_pkg::ST_IDLE;
        end
      end
      qtt_pkg::ST_FLUSH: begin
        state_next = q_valid ? qtt_pkg::ST_EXEC : qtt_pkg::ST_IDLE;
      end
      default: state_next = qtt_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = cur_idx;
    mem_wd    = upd;
    rd_en     = 1'b0;
    rd_addr   = match_idx;
    set_valid = 1'b0;
    clr_valid = 1'b0;
    clr_idx   = cur_idx;
    emit      = 1'b0;
    emit_res  = '{id: pend_id, kind: pend_kind, outcome: qtt_pkg::OUTCOME_TIMEOUT,
                  value: 32'd0, last: 1'b0};
    unique case (state)
      qtt_pkg::ST_IDLE: begin
        q_pop = q_valid;
      end
      qtt_pkg::ST_EXEC: begin
        unique case (cur.action)
          qtt_pkg::ACT_OPEN: begin
            q_pop = q_valid;
            if (free_hit) begin
              mem_we            = 1'b1;
              mem_wa            = free_idx;
              mem_wd.id         = cur.id;
              mem_wd.kind       = cur.kind;
              mem_wd.left       = (quorum_count == 3'd0) ? 3'd1 : quorum_count;
              mem_wd.start      = cur.now;
              mem_wd.best_stamp = 16'd0;
              mem_wd.best_value = 32'd0;
              set_valid         = 1'b1;
            end else begin
              emit     = 1'b1;
              emit_res = '{id: cur.id, kind: cur.kind, outcome: qtt_pkg::OUTCOME_FULL,
                           value: 32'd0, last: 1'b1};
            end
          end
          qtt_pkg::ACT_WRITE_REPLY, qtt_pkg::ACT_READ_REPLY: begin
            if (match_hit) begin
              rd_en = 1'b1;
            end else begin
              q_pop = q_valid;
            end
          end
          default: ;
        endcase
      end
      qtt_pkg::ST_UPDATE: begin
        q_pop  = q_valid;
        mem_we = 1'b1;
        if (reach) begin
          clr_valid = 1'b1;
          emit      = 1'b1;
          emit_res  = '{id: rd_data.id, kind: rd_data.kind,
                        outcome: qtt_pkg::OUTCOME_QUORUM,
                        value: (rd_data.kind == qtt_pkg::KIND_READ) ? upd.best_value : 32'd0,
                        last: 1'b1};
        end
      end
      qtt_pkg::ST_SCAN: begin
        rd_en   = scan_issue;
        rd_addr = scan_idx;
        q_pop   = q_valid & scan_finish;
        if (expire) begin
          clr_valid = 1'b1;
          clr_idx   = chk_idx;
          emit      = pend_vld;
        end
      end
      qtt_pkg::ST_FLUSH: begin
        q_pop         = q_valid;
        emit          = 1'b1;
        emit_res.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= qtt_pkg::ST_IDLE;
      slot_valid <= '0;
      res_valid  <= 1'b0;
      scan_issue <= 1'b0;
      chk_vld    <= 1'b0;
      chk_end    <= 1'b0;
      pend_vld   <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= emit;
      if (set_valid) slot_valid[mem_wa] <= 1'b1;
      if (clr_valid) slot_valid[clr_idx] <= 1'b0;
      if (state == qtt_pkg::ST_EXEC && cur.action == qtt_pkg::ACT_TICK) begin
        scan_issue <= 1'b1;
        chk_vld    <= 1'b0;
        chk_end    <= 1'b0;
        pend_vld   <= 1'b0;
      end else if (state == qtt_pkg::ST_SCAN) begin
        chk_vld <= scan_issue & slot_valid[scan_idx];
        chk_end <= scan_issue & (scan_idx == LAST_IDX);
        if (scan_issue && scan_idx == LAST_IDX) scan_issue <= 1'b0;
        if (expire) pend_vld <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_cmd;
    if (state == qtt_pkg::ST_EXEC) cur_idx <= match_idx;
    if (set_valid) slot_id[mem_wa] <= cur.id;
    if (mem_we) table_mem[mem_wa] <= mem_wd;
    if (rd_en) rd_data <= table_mem[rd_addr];
    if (emit) res <= emit_res;
    if (state == qtt_pkg::ST_EXEC && cur.action == qtt_pkg::ACT_TICK) begin
      scan_idx <= '0;
      tcount   <= '0;
    end else if (state == qtt_pkg::ST_SCAN) begin
      chk_idx <= scan_idx;
      if (scan_issue && scan_idx != LAST_IDX) scan_idx <= scan_idx + 1'b1;
      if (expire) begin
        pend_id   <= rd_data.id;
        pend_kind <= rd_data.kind;
        tcount    <= tcount + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/quorum_transaction_tracker.sv -----
// Top level of the quorum transaction tracker: config registers and stage wiring.
//
// Usage:
//   Command channel: a transaction is taken at a rising edge with start high and
//   busy low. action selects open, write reply, read reply or time tick.
//   Result channel: result_valid marks each result for exactly one cycle; the
//   receiver cannot stall it. last flags the final result of one transaction.
//   Config channel: cfg_valid/cfg_ready with cfg_index 0 = quorum_count,
//   1 = wait_time; other indexes are dropped. Write only while the block is idle.
// Timing:
//   The front register takes a transaction every cycle while the queue has room;
//   the table engine behind the queue handles an open or an unmatched reply in
//   its exec state, a matched reply with a table memory read, then a write back,
//   and a tick with a scan of the slots, one slot per cycle through the memory
//   read port. Each result is driven from a register in the table engine.
// Reset:
//   rst clears every slot, the queue and the front register, and loads
//   quorum_count = 2, wait_time = 20. No clearing pass is needed.
`default_nettype none
module quorum_transaction_tracker #(
  parameter int TRANS_SLOTS = qtt_pkg::TRANS_SLOTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     action,
  input  wire logic [15:0]                    trans_id,
  input  wire logic [1:0]                     kind,
  input  wire logic                           ok,
  input  wire logic                           found,
  input  wire logic [15:0]                    reply_stamp,
  input  wire logic [31:0]                    reply_value,
  input  wire logic [15:0]                    now_time,
  output logic                                result_valid,
  output logic [15:0]                         done_id,
  output logic [1:0]                          done_kind,
  output logic [1:0]                          outcome,
  output logic [31:0]                         best_value,
  output logic                                last,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [qtt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [qtt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [2:0]       quorum_count;
  logic [15:0]      wait_time;
  qtt_pkg::item_t   item;
  logic             push_valid;
  logic             push_ready;
  qtt_pkg::cmd_t    push_cmd;
  logic             q_valid;
  logic             q_pop;
  qtt_pkg::cmd_t    q_cmd;
  qtt_pkg::result_t res;

  // Config writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      quorum_count <= qtt_pkg::QUORUM_COUNT_RST;
      wait_time    <= qtt_pkg::WAIT_TIME_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        qtt_pkg::CFG_QUORUM_COUNT: quorum_count <= cfg_data[2:0];
        qtt_pkg::CFG_WAIT_TIME:    wait_time    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Bundle the command fields for the front stage.
  always_comb begin
    item.action      = qtt_pkg::action_t'(action);
    item.trans_id    = trans_id;
    item.kind        = kind;
    item.ok          = ok;
    item.found       = found;
    item.reply_stamp = reply_stamp;
    item.reply_value = reply_value;
    item.now_time    = now_time;
  end

  // Accept and filter: failed write replies and empty read replies drop here.
  qtt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .item       (item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // Hold a couple of commands so the front keeps taking work while a tick scans.
  qtt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_cmd    (push_cmd),
    .out_valid (q_valid),
    .out_pop   (q_pop),
    .out_cmd   (q_cmd)
  );

  // Carry out opens, replies and ticks against the slot table.
  qtt_back #(
    .TRANS_SLOTS (TRANS_SLOTS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop),
    .quorum_count (quorum_count),
    .wait_time    (wait_time),
    .res_valid    (result_valid),
    .res          (res)
  );

  assign done_id    = res.id;
  assign done_kind  = res.kind;
  assign outcome    = res.outcome;
  assign best_value = res.value;
  assign last       = res.last;

endmodule
`default_nettype wire

// ----- tb/qtt_checker.sv -----
// Checker for the quorum transaction tracker: predicts every result and compares it.
`default_nettype none
module qtt_checker #(
  parameter int TRANS_SLOTS = qtt_pkg::TRANS_SLOTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic                           busy,
  input  wire logic [1:0]                     action,
  input  wire logic [15:0]                    trans_id,
  input  wire logic [1:0]                     kind,
  input  wire logic                           ok,
  input  wire logic                           found,
  input  wire logic [15:0]                    reply_stamp,
  input  wire logic [31:0]                    reply_value,
  input  wire logic [15:0]                    now_time,
  input  wire logic                           result_valid,
  input  wire logic [15:0]                    done_id,
  input  wire logic [1:0]                     done_kind,
  input  wire logic [1:0]                     outcome,
  input  wire logic [31:0]                    best_value,
  input  wire logic                           last,
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_ready,
  input  wire logic [qtt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [qtt_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                  fail_count,
  output int                                  pending_count,
  output int                                  result_count,
  output int                                  timeout_count,
  output int                                  full_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import qtt_pkg::*;

  logic [2:0]  quorum_reg;
  logic [15:0] wait_reg;
  logic        live [TRANS_SLOTS];
  entry_t      slots [TRANS_SLOTS];
  result_t     done_q [$];
  item_t       seen;
  int          errors = 0;
  int          n_results = 0;
  int          n_timeouts = 0;
  int          n_full = 0;

  initial begin
    fail_count    = 0;
    pending_count = 0;
    result_count  = 0;
    timeout_count = 0;
    full_count    = 0;
  end

  task automatic mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
    errors++;
    $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
  endtask

  // Match one observed result against the oldest predicted one.
  task automatic compare_result();
    result_t want;
    n_results++;
    if (outcome == OUTCOME_TIMEOUT) n_timeouts++;
    if (outcome == OUTCOME_FULL) n_full++;
    if (done_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, none predicted: id %0h outcome %0d",
               $time, done_id, outcome);
    end else begin
      want = done_q.pop_front();
      if (done_id !== want.id) mismatch("done_id", 32'(want.id), 32'(done_id));
      if (done_kind !== want.kind) mismatch("done_kind", 32'(want.kind), 32'(done_kind));
      if (outcome !== want.outcome) mismatch("outcome", 32'(want.outcome), 32'(outcome));
      if (best_value !== want.value) mismatch("best_value", want.value, best_value);
      if (last !== want.last) mismatch("last", 32'(want.last), 32'(last));
    end
  endtask

  function automatic int lowest_match(input logic [15:0] id);
    int hit;
    hit = -1;
    for (int i = TRANS_SLOTS - 1; i >= 0; i--)
      if (live[i] && slots[i].id == id) hit = i;
    return hit;
  endfunction

  // Advance the shadow table by one transaction and queue what it reports.
  task automatic predict_txn(input item_t it);
    int      slot;
    int      first;
    result_t r;
    logic [15:0] elapsed;
    slot  = -1;
    first = done_q.size();
    r     = '0;
    case (it.action)
      ACT_OPEN: begin
        for (int i = TRANS_SLOTS - 1; i >= 0; i--)
          if (!live[i]) slot = i;
        if (slot < 0) begin
          r.id      = it.trans_id;
          r.kind    = it.kind;
          r.outcome = OUTCOME_FULL;
          done_q.push_back(r);
        end else begin
          live[slot]             = 1'b1;
          slots[slot].id         = it.trans_id;
          slots[slot].kind       = it.kind;
          slots[slot].left       = (quorum_reg == 3'd0) ? 3'd1 : quorum_reg;
          slots[slot].start      = it.now_time;
          slots[slot].best_stamp = '0;
          slots[slot].best_value = '0;
        end
      end
      ACT_WRITE_REPLY, ACT_READ_REPLY: begin
        if ((it.action == ACT_WRITE_REPLY && it.ok) || (it.action == ACT_READ_REPLY && it.found))
          slot = lowest_match(it.trans_id);
        if (slot >= 0) begin
          // Keep the newer or equal value before counting down.
          if (it.action == ACT_READ_REPLY && it.reply_stamp >= slots[slot].best_stamp) begin
            slots[slot].best_stamp = it.reply_stamp;
            slots[slot].best_value = it.reply_value;
          end
          if (slots[slot].left <= 3'd1) begin
            slots[slot].left = '0;
            live[slot]       = 1'b0;
            r.id      = slots[slot].id;
            r.kind    = slots[slot].kind;
            r.outcome = OUTCOME_QUORUM;
            r.value   = (slots[slot].kind == KIND_READ) ? slots[slot].best_value : '0;
            done_q.push_back(r);
          end else begin
            slots[slot].left = slots[slot].left - 3'd1;
          end
        end
      end
      default: begin
        for (int i = 0; i < TRANS_SLOTS; i++) begin
          elapsed = it.now_time - slots[i].start;
          if (live[i] && done_q.size() - first < MAX_RESULTS && elapsed > wait_reg) begin
            live[i]   = 1'b0;
            r.id      = slots[i].id;
            r.kind    = slots[i].kind;
            r.outcome = OUTCOME_TIMEOUT;
            r.value   = '0;
            done_q.push_back(r);
          end
        end
      end
    endcase
    if (done_q.size() > first) done_q[done_q.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      quorum_reg = QUORUM_COUNT_RST;
      wait_reg   = WAIT_TIME_RST;
      for (int i = 0; i < TRANS_SLOTS; i++) live[i] = 1'b0;
      done_q.delete();
    end else begin
      if (result_valid) compare_result();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_QUORUM_COUNT: quorum_reg = cfg_data[2:0];
          CFG_WAIT_TIME:    wait_reg   = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        seen.action      = action_t'(action);
        seen.trans_id    = trans_id;
        seen.kind        = kind;
        seen.ok          = ok;
        seen.found       = found;
        seen.reply_stamp = reply_stamp;
        seen.reply_value = reply_value;
        seen.now_time    = now_time;
        predict_txn(seen);
      end
    end
    fail_count    <= errors;
    pending_count <= done_q.size();
    result_count  <= n_results;
    timeout_count <= n_timeouts;
    full_count    <= n_full;
  end

endmodule
`default_nettype wire

// ----- tb/tb_quorum_transaction_tracker.sv -----
// Top of the quorum transaction tracker testbench: stimulus, register phases and verdict.
`default_nettype none
module tb_quorum_transaction_tracker;
  timeunit 1ns;
  timeprecision 1ps;
  import qtt_pkg::*;

  localparam int SLOTS         = TRANS_SLOTS_DEF;
  localparam int PHASES        = 6;
  localparam int PHASE_TXNS    = 72;
  // A tick walks every slot through the memory port, and two more may sit in the
  // queue, so give the engine several scans of slack before touching a register.
  localparam int SETTLE_CYCLES = 3 * SLOTS + 30;
  localparam int POOL_SIZE     = 6;

  // Kind codes beside the read code that the package carries.
  localparam logic [1:0] KIND_CREATE = 2'd0;
  localparam logic [1:0] KIND_UPDATE = 2'd2;
  localparam logic [1:0] KIND_DELETE = 2'd3;
  // A register index the block has no register for; the write must be dropped.
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd2;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic [1:0]             action;
  logic [15:0]            trans_id;
  logic [1:0]             kind;
  logic                   ok;
  logic                   found;
  logic [15:0]            reply_stamp;
  logic [31:0]            reply_value;
  logic [15:0]            now_time;
  logic                   result_valid;
  logic [15:0]            done_id;
  logic [1:0]             done_kind;
  logic [1:0]             outcome;
  logic [31:0]            best_value;
  logic                   last;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int fail_count;
  int pending_count;
  int result_count;
  int timeout_count;
  int full_count;

  // Stimulus-side bookkeeping: a running clock of message time, the ids in play
  // for the current phase, and the burst pacing of the sender.
  logic [15:0] now_ctr;
  logic [15:0] id_pool [POOL_SIZE];
  int          wait_cur;
  int          burst_left;
  bit          steady;
  int          txns_sent;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quorum_transaction_tracker #(.TRANS_SLOTS(SLOTS)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .trans_id(trans_id), .kind(kind), .ok(ok), .found(found),
    .reply_stamp(reply_stamp), .reply_value(reply_value), .now_time(now_time),
    .result_valid(result_valid), .done_id(done_id), .done_kind(done_kind),
    .outcome(outcome), .best_value(best_value), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  qtt_checker #(.TRANS_SLOTS(SLOTS)) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .trans_id(trans_id), .kind(kind), .ok(ok), .found(found),
    .reply_stamp(reply_stamp), .reply_value(reply_value), .now_time(now_time),
    .result_valid(result_valid), .done_id(done_id), .done_kind(done_kind),
    .outcome(outcome), .best_value(best_value), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count), .result_count(result_count),
    .timeout_count(timeout_count), .full_count(full_count)
  );

  function automatic item_t txn(input action_t a, input logic [15:0] id, input logic [1:0] k,
                                input logic okv, input logic fnd, input logic [15:0] st,
                                input logic [31:0] val, input logic [15:0] nw);
    item_t it;
    it.action      = a;
    it.trans_id    = id;
    it.kind        = k;
    it.ok          = okv;
    it.found       = fnd;
    it.reply_stamp = st;
    it.reply_value = val;
    it.now_time    = nw;
    return it;
  endfunction

  // Build one random transaction. Most are well formed: opens and replies on a
  // small id pool so replies land on live entries and duplicates happen; ticks
  // sometimes jump the clock past the wait time. A tenth is pure noise.
  function automatic item_t make_txn();
    item_t it;
    int    pick;
    it.action      = ACT_OPEN;
    it.trans_id    = id_pool[$urandom_range(0, POOL_SIZE - 1)];
    it.kind        = 2'($urandom_range(0, 3));
    it.ok          = ($urandom_range(0, 9) != 0);
    it.found       = ($urandom_range(0, 9) != 0);
    it.reply_stamp = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 15)) : 16'($urandom);
    it.reply_value = $urandom;
    now_ctr        = now_ctr + 16'($urandom_range(0, 4));
    it.now_time    = now_ctr;
    pick           = $urandom_range(0, 99);
    if (pick < 10) begin
      it.action   = action_t'($urandom_range(0, 3));
      it.trans_id = 16'($urandom);
      it.ok       = 1'($urandom);
      it.found    = 1'($urandom);
      it.now_time = 16'($urandom);
    end else if (pick < 40) begin
      it.action = ACT_OPEN;
    end else if (pick < 62) begin
      it.action = ACT_WRITE_REPLY;
    end else if (pick < 88) begin
      it.action = ACT_READ_REPLY;
    end else begin
      it.action = ACT_TICK;
      if ($urandom_range(0, 2) == 0) begin
        now_ctr     = now_ctr + 16'($urandom_range(0, wait_cur + 2));
        it.now_time = now_ctr;
      end
    end
    // Aim some replies at ids nobody opened.
    if (pick >= 10 && it.action != ACT_OPEN && $urandom_range(0, 6) == 0)
      it.trans_id = 16'($urandom);
    return it;
  endfunction

  // Present one transaction and hold it until the block takes it; then advance
  // the burst pacing and drop start for a random gap when a burst ends.
  task automatic send_txn(input item_t it);
    int gap;
    start       <= 1'b1;
    action      <= it.action;
    trans_id    <= it.trans_id;
    kind        <= it.kind;
    ok          <= it.ok;
    found       <= it.found;
    reply_stamp <= it.reply_stamp;
    reply_value <= it.reply_value;
    now_time    <= it.now_time;
    @(posedge clk);
    while (busy) @(posedge clk);
    txns_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold the sender off until every predicted result has come, then idle on.
  task automatic settle(input int extra);
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Leave cfg_valid high on return; the caller drops it after its last write.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic run_directed();
    steady  = 1'b1;
    now_ctr = 16'hFFFA;
    // Fill every slot just before the time wraps, ids from 0 up to all ones.
    for (int k = 0; k < SLOTS; k++)
      send_txn(txn(ACT_OPEN, 16'(k * 16'h1111), 2'(k), 1'b0, 1'b0, 16'($urandom), $urandom,
                   now_ctr));
    // One more open finds the table full.
    send_txn(txn(ACT_OPEN, 16'hABCD, KIND_DELETE, 1'b1, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, now_ctr));
    // Waited exactly the wait time: nothing expires. One tick later, across the
    // wrap, every slot expires at once.
    send_txn(txn(ACT_TICK, 16'h0000, KIND_CREATE, 1'b0, 1'b0, 16'h0000, 32'h0, 16'h000E));
    send_txn(txn(ACT_TICK, 16'hFFFF, KIND_DELETE, 1'b1, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 16'h000F));
    // Read transaction: equal stamps keep the newer value, the final reply's too;
    // failed, empty and unknown replies leave it alone.
    send_txn(txn(ACT_OPEN, 16'h1234, KIND_READ, 1'b0, 1'b0, 16'h0, 32'h0, 16'h0010));
    send_txn(txn(ACT_READ_REPLY, 16'h1234, KIND_CREATE, 1'b0, 1'b1, 16'h0000, 32'hFFFF_FFFF,
                 16'h0011));
    send_txn(txn(ACT_READ_REPLY, 16'h1234, KIND_CREATE, 1'b1, 1'b0, 16'hFFFF, 32'h5A5A_5A5A,
                 16'h0011));
    send_txn(txn(ACT_WRITE_REPLY, 16'h1234, KIND_CREATE, 1'b0, 1'b1, 16'h0, 32'h0, 16'h0012));
    send_txn(txn(ACT_WRITE_REPLY, 16'h4321, KIND_CREATE, 1'b1, 1'b0, 16'h0, 32'h0, 16'h0012));
    send_txn(txn(ACT_READ_REPLY, 16'h1234, KIND_CREATE, 1'b0, 1'b1, 16'h0000, 32'hA5A5_A5A5,
                 16'h0013));
    // Duplicate id: replies go to the lower slot; mixed reply types count down.
    send_txn(txn(ACT_OPEN, 16'h0077, KIND_UPDATE, 1'b0, 1'b0, 16'h0, 32'h0, 16'h0014));
    send_txn(txn(ACT_OPEN, 16'h0077, KIND_CREATE, 1'b0, 1'b0, 16'h0, 32'h0, 16'h0014));
    send_txn(txn(ACT_WRITE_REPLY, 16'h0077, KIND_CREATE, 1'b1, 1'b0, 16'h0, 32'h0, 16'h0015));
    send_txn(txn(ACT_READ_REPLY, 16'h0077, KIND_CREATE, 1'b0, 1'b1, 16'h0007, 32'h1357_9BDF,
                 16'h0015));
    // An older stamp must not replace the kept value.
    send_txn(txn(ACT_OPEN, 16'h00C3, KIND_READ, 1'b0, 1'b0, 16'h0, 32'h0, 16'h0016));
    send_txn(txn(ACT_READ_REPLY, 16'h00C3, KIND_CREATE, 1'b0, 1'b1, 16'hFFFF, 32'hCAFE_0001,
                 16'h0017));
    send_txn(txn(ACT_READ_REPLY, 16'h00C3, KIND_CREATE, 1'b0, 1'b1, 16'h0003, 32'h0000_0002,
                 16'h0017));
    now_ctr = 16'h0018;
    steady  = 1'b0;
  endtask

  task automatic run_random();
    for (int i = 0; i < PHASE_TXNS; i++) begin
      // Pause mid-phase until the block has reported everything it owes.
      if (i == PHASE_TXNS / 2) settle(0);
      send_txn(make_txn());
    end
  endtask

  initial begin
    logic [2:0]  qc;
    logic [15:0] wt;
    rst         <= 1'b1;
    start       <= 1'b0;
    action      <= ACT_OPEN;
    trans_id    <= '0;
    kind        <= KIND_CREATE;
    ok          <= 1'b0;
    found       <= 1'b0;
    reply_stamp <= '0;
    reply_value <= '0;
    now_time    <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= CFG_QUORUM_COUNT;
    cfg_data    <= '0;
    burst_left  = 8;
    steady      = 1'b0;
    txns_sent   = 0;
    wait_cur    = WAIT_TIME_RST;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings first, then one phase per register setting.
    run_directed();
    for (int p = 0; p < PHASES; p++) begin
      settle(SETTLE_CYCLES);
      case (p)
        0:       begin qc = 3'd7; wt = 16'hFFFF; end
        1:       begin qc = 3'd1; wt = 16'd1;    end
        2:       begin qc = 3'd0; wt = 16'd8;    end
        3:       begin qc = 3'd3; wt = 16'($urandom_range(10, 60)); end
        4:       begin qc = 3'($urandom_range(0, 7)); wt = 16'($urandom_range(1, 200)); end
        default: begin qc = 3'd2; wt = 16'd30;   end
      endcase
      // Upper data bits of the quorum write carry junk; only the low three count.
      write_reg(CFG_QUORUM_COUNT, {13'($urandom), qc});
      write_reg(CFG_WAIT_TIME, wt);
      if (p == PHASES - 1) write_reg(CFG_UNUSED, 16'($urandom));
      cfg_valid <= 1'b0;
      wait_cur = (wt > 16'd1000) ? 1000 : int'(wt);
      for (int k = 0; k < POOL_SIZE; k++) id_pool[k] = 16'($urandom);
      run_random();
    end

    settle(SETTLE_CYCLES);
    $display("Ran %0d transactions over %0d register settings and checked %0d results,",
             txns_sent, PHASES + 1, result_count);
    $display("including %0d timeouts and %0d table-full refusals.", timeout_count, full_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/qtt_pkg.sv
rtl/qtt_front.sv
rtl/qtt_queue.sv
rtl/qtt_back.sv
rtl/quorum_transaction_tracker.sv
tb/qtt_checker.sv
tb/tb_quorum_transaction_tracker.sv
